>>> rtl/pce_pkg.sv
// Shared types, constants and the polymod fold step for the checksum encoder.
// No dependencies.
package pce_pkg;

  localparam int CHECK_W = 40;
  localparam int SYM_W   = 5;

  // Work-queue depth between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Generator terms of the 40-bit polymod.
  localparam logic [CHECK_W-1:0] GEN [SYM_W] = '{
    40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
    40'hae2eabe2a8, 40'h1e4f43e470
  };

  localparam logic [CHECK_W-1:0] CHECK_INIT = 40'h1;

  // Work kinds.
  localparam logic [1:0] OP_FOLD   = 2'd0;  // fold symbol, no output
  localparam logic [1:0] OP_EMIT   = 2'd1;  // fold symbol and emit it
  localparam logic [1:0] OP_FINISH = 2'd2;  // fold zeros, emit checksum

  typedef struct packed {
    logic [1:0]       kind;
    logic [SYM_W-1:0] sym;
  } entry_t;

  // One polymod step: shift in a symbol, reduce by the top five bits.
  function automatic logic [CHECK_W-1:0] pce_fold(input logic [CHECK_W-1:0] cv,
                                                  input logic [SYM_W-1:0]   sym);
    logic [SYM_W-1:0]   top;
    logic [CHECK_W-1:0] c;
    top = cv[CHECK_W-1 -: SYM_W];
    c   = {cv[CHECK_W-SYM_W-1:0], sym};
    for (int j = 0; j < SYM_W; j++) begin
      if (top[j]) begin
        c = c ^ GEN[j];
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/pce_front.sv
// Front end: accepts requests, tracks separator and bit regrouping, and
// turns each request into a short list of work entries. Uses pce_pkg.
module pce_front import pce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_last,
  output logic       push_valid,
  output entry_t     push_entry,
  input  logic       q_full
);

  localparam int PEND_N = 5;  // separator, two symbols, pad, finish

  entry_t      pend_r   [PEND_N];
  entry_t      pend_nxt [PEND_N];
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic        sep_r, sep_nxt;
  logic [3:0]  lb_r, lb_nxt;
  logic [2:0]  lc_r, lc_nxt;

  entry_t      list [PEND_N];
  logic [2:0]  n;
  logic        push, accept;
  logic [11:0] acc;
  logic [3:0]  bits, sh1, sh2;
  logic        two;
  logic [2:0]  new_lc;
  logic [3:0]  new_lb;
  logic [4:0]  sym1, sym2, pad;
  logic [11:0] lb_mask;

  assign push_valid = (pend_cnt_r != 3'd0);
  assign push_entry = pend_r[0];
  assign push       = push_valid && !q_full;
  assign in_ready   = (pend_cnt_r == 3'd0) || (pend_cnt_r == 3'd1 && !q_full);
  assign accept     = in_valid && in_ready;

  // Regrouping: 12-bit window of leftover bits and the new byte.
  always_comb begin
    acc     = {lb_r, in_data_byte};
    bits    = 4'(lc_r) + 4'd8;
    sh1     = bits - 4'd5;
    sh2     = bits - 4'd10;
    two     = (lc_r >= 3'd2);
    sym1    = 5'(acc >> sh1);
    sym2    = 5'(acc >> sh2);
    new_lc  = two ? (lc_r - 3'd2) : (lc_r + 3'd3);
    lb_mask = (12'd1 << new_lc) - 12'd1;
    new_lb  = 4'(acc & lb_mask);
    pad     = 5'({1'b0, new_lb} << (3'd5 - new_lc));
  end

  // Work list and state update for the presented request.
  always_comb begin
    for (int i = 0; i < PEND_N; i++) begin
      list[i] = '0;
    end
    n       = 3'd0;
    sep_nxt = sep_r;
    lb_nxt  = lb_r;
    lc_nxt  = lc_r;
    if (!in_cmd) begin
      if (!sep_r) begin
        list[0] = '{kind: OP_FOLD, sym: in_data_byte[4:0]};
        n       = 3'd1;
      end
    end else begin
      if (!sep_r) begin
        list[n] = '{kind: OP_FOLD, sym: 5'd0};
        n       = n + 3'd1;
      end
      list[n] = '{kind: OP_EMIT, sym: sym1};
      n       = n + 3'd1;
      if (two) begin
        list[n] = '{kind: OP_EMIT, sym: sym2};
        n       = n + 3'd1;
      end
      sep_nxt = 1'b1;
      lb_nxt  = new_lb;
      lc_nxt  = new_lc;
      if (in_is_last) begin
        if (new_lc != 3'd0) begin
          list[n] = '{kind: OP_EMIT, sym: pad};
          n       = n + 3'd1;
        end
        list[n] = '{kind: OP_FINISH, sym: 5'd0};
        n       = n + 3'd1;
        sep_nxt = 1'b0;
        lb_nxt  = 4'd0;
        lc_nxt  = 3'd0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PEND_N; i++) begin
      pend_nxt[i] = pend_r[i];
    end
    pend_cnt_nxt = pend_cnt_r;
    if (push) begin
      for (int i = 0; i < PEND_N - 1; i++) begin
        pend_nxt[i] = pend_r[i+1];
      end
      pend_cnt_nxt = pend_cnt_r - 3'd1;
    end
    if (accept) begin
      for (int i = 0; i < PEND_N; i++) begin
        pend_nxt[i] = list[i];
      end
      pend_cnt_nxt = n;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < PEND_N; i++) begin
      pend_r[i] <= pend_nxt[i];
    end
    if (!rst_n) begin
      pend_cnt_r <= 3'd0;
      sep_r      <= 1'b0;
      lb_r       <= 4'd0;
      lc_r       <= 3'd0;
    end else begin
      pend_cnt_r <= pend_cnt_nxt;
      if (accept) begin
        sep_r <= sep_nxt;
        lb_r  <= lb_nxt;
        lc_r  <= lc_nxt;
      end
    end
  end

endmodule

>>> rtl/pce_queue.sv
// Short FIFO of work entries between front and back end.
// Uses pce_pkg.
module pce_queue import pce_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  entry_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/pce_back.sv
// Back end: runs the polymod, emits payload and checksum symbols through
// an output register. Uses pce_pkg.
module pce_back import pce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             empty,
  input  entry_t           head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_is_checksum,
  output logic             out_last_symbol
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ZFOLD = 2'd1;  // folding the eight zero symbols
  localparam logic [1:0] ST_CSUM  = 2'd2;  // shifting out the checksum

  logic [1:0]         state_r, state_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [CHECK_W-1:0] cv_r, cv_nxt;
  logic               ov_r, ov_nxt;
  logic [SYM_W-1:0]   osym_r, osym_nxt;
  logic               ochk_r, ochk_nxt;
  logic               olast_r, olast_nxt;
  logic               out_free;

  assign out_free        = !ov_r || out_ready;
  assign out_valid       = ov_r;
  assign out_symbol      = osym_r;
  assign out_is_checksum = ochk_r;
  assign out_last_symbol = olast_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cv_nxt    = cv_r;
    ov_nxt    = ov_r && !out_ready;
    osym_nxt  = osym_r;
    ochk_nxt  = ochk_r;
    olast_nxt = olast_r;
    pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          case (head.kind)
            OP_EMIT: begin
              if (out_free) begin
                pop       = 1'b1;
                cv_nxt    = pce_fold(cv_r, head.sym);
                ov_nxt    = 1'b1;
                osym_nxt  = head.sym;
                ochk_nxt  = 1'b0;
                olast_nxt = 1'b0;
              end
            end
            OP_FINISH: begin
              pop       = 1'b1;
              cnt_nxt   = 3'd0;
              state_nxt = ST_ZFOLD;
            end
            OP_FOLD: begin
              pop    = 1'b1;
              cv_nxt = pce_fold(cv_r, head.sym);
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      ST_ZFOLD: begin
        cv_nxt  = pce_fold(cv_r, '0);
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          cv_nxt    = pce_fold(cv_r, '0) ^ CHECK_INIT;
          state_nxt = ST_CSUM;
        end
      end
      ST_CSUM: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          osym_nxt  = cv_r[CHECK_W-1 -: SYM_W];
          ochk_nxt  = 1'b1;
          olast_nxt = (cnt_r == 3'd7);
          cv_nxt    = {cv_r[CHECK_W-SYM_W-1:0], {SYM_W{1'b0}}};
          cnt_nxt   = cnt_r + 3'd1;
          if (cnt_r == 3'd7) begin
            cv_nxt    = CHECK_INIT;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    osym_r  <= osym_nxt;
    ochk_r  <= ochk_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 3'd0;
      cv_r    <= CHECK_INIT;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cv_r    <= cv_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule

>>> rtl/polymod_checksum_payload_encoder.sv
// Top level of the polymod checksum payload encoder.
// Depends on pce_pkg, pce_front, pce_queue and pce_back.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_ready   in_cmd, in_data_byte, in_is_last
//   out_     out  out_valid / out_ready out_symbol, out_is_checksum, out_last_symbol
//
// Work: the front end pushes one work entry per cycle while the queue is not
// full; a payload byte gives 1 or 2 entries, one more for the first byte
// (separator fold) and up to two more for the final byte (pad symbol,
// checksum entry); a prefix gives 1, or none once the payload has begun.
// The back end takes one entry per cycle unless an emit waits on the output
// register or a checksum runs; the checksum entry then folds eight zeros and
// shifts out eight checksum symbols. Reset is synchronous, active low. Either
// side may stall: a 4-entry queue and the output register decouple the two sides.
module polymod_checksum_payload_encoder import pce_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_cmd,
  input  logic [7:0]       in_data_byte,
  input  logic             in_is_last,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_is_checksum,
  output logic             out_last_symbol
);

  // Front-to-queue and queue-to-back work entries.
  entry_t push_entry, head;
  logic   push_valid, q_full, q_empty, pop;

  // Front: classifies prefix/payload requests, regroups bytes to symbols,
  // drops prefix characters that arrive after the payload has started.
  pce_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_is_last   (in_is_last),
    .push_valid   (push_valid),
    .push_entry   (push_entry),
    .q_full       (q_full)
  );

  // Queue: lets the front keep taking requests while the back emits.
  pce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  // Back: 40-bit polymod, symbol output register, checksum sequencer.
  pce_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_is_checksum (out_is_checksum),
    .out_last_symbol (out_last_symbol)
  );

endmodule

>>> sim/polymod_checksum_payload_encoder_tb.sv
// Self-checking bench for polymod_checksum_payload_encoder: random prefix and payload
// requests with a scoreboard that predicts every payload and checksum symbol.
// Depends on pce_pkg and the encoder RTL.
`timescale 1ns / 1ps

module polymod_checksum_payload_encoder_tb;
  import pce_pkg::*;

  // Request kinds on in_cmd.
  localparam bit CMD_PREFIX  = 1'b0;
  localparam bit CMD_PAYLOAD = 1'b1;

  // Cycles without any handshake before the run is declared hung. The long
  // receiver hold-offs are far shorter than this.
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 100;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_REQUESTS = 450;

  typedef struct {
    logic [SYM_W-1:0] sym;
    bit               is_chk;
    bit               fin;
  } symbol_t;

  // Tracks the running 40-bit polymod and the 8-to-5 bit regrouping, and
  // holds the symbols the encoder still owes us, oldest first.
  class symbol_scoreboard;
    logic [39:0]  poly;
    logic [3:0]   spare_bits;
    int unsigned  spare_cnt;
    bit           payload_begun;
    symbol_t      owed_q[$];
    int unsigned  errors;
    int unsigned  symbols_checked;
    int unsigned  addresses_closed;

    function new();
      restart();
      errors           = 0;
      symbols_checked  = 0;
      addresses_closed = 0;
    endfunction

    function void restart();
      poly          = 40'h1;
      spare_bits    = '0;
      spare_cnt     = 0;
      payload_begun = 1'b0;
    endfunction

    // Shift one symbol into the polymod and reduce by the top five bits.
    function void fold(logic [4:0] s);
      logic [4:0]  top;
      logic [39:0] nxt;
      top = poly[39:35];
      nxt = {poly[34:0], s};
      if (top[0]) nxt = nxt ^ 40'h98f2bc8e61;
      if (top[1]) nxt = nxt ^ 40'h79b76d99e2;
      if (top[2]) nxt = nxt ^ 40'hf33e5fb3c4;
      if (top[3]) nxt = nxt ^ 40'hae2eabe2a8;
      if (top[4]) nxt = nxt ^ 40'h1e4f43e470;
      poly = nxt;
    endfunction

    function void owe(logic [4:0] s, bit is_chk, bit fin);
      symbol_t e;
      e.sym    = s;
      e.is_chk = is_chk;
      e.fin    = fin;
      owed_q.push_back(e);
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Returns 1 when the encoder is expected to drop the request.
    function bit note_request(bit cmd, logic [7:0] b, bit last);
      logic [11:0] acc;
      logic [4:0]  sym;
      logic [39:0] final_cv;
      int unsigned nbits;
      if (cmd == CMD_PREFIX) begin
        if (payload_begun) return 1'b1;
        fold(b[4:0]);
        return 1'b0;
      end
      if (!payload_begun) begin
        fold(5'd0);
        payload_begun = 1'b1;
      end
      acc   = {spare_bits, b};
      nbits = spare_cnt + 8;
      while (nbits >= 5) begin
        nbits = nbits - 5;
        sym   = 5'(acc >> nbits);
        fold(sym);
        owe(sym, 1'b0, 1'b0);
      end
      spare_cnt  = nbits;
      spare_bits = 4'(acc & ((12'd1 << nbits) - 12'd1));
      if (last) begin
        if (spare_cnt > 0) begin
          sym = {1'b0, spare_bits} << (5 - spare_cnt);
          fold(sym);
          owe(sym, 1'b0, 1'b0);
        end
        repeat (8) fold(5'd0);
        final_cv = poly ^ 40'h1;
        for (int i = 0; i < 8; i++) owe(final_cv[39-5*i -: 5], 1'b1, i == 7);
        addresses_closed++;
        restart();
      end
      return 1'b0;
    endfunction

    function void check_result(logic [4:0] s, logic is_chk, logic fin);
      symbol_t e;
      if (owed_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected symbol %0d (checksum %0b, last %0b)", $time, s, is_chk, fin);
        return;
      end
      e = owed_q.pop_front();
      symbols_checked++;
      if (s !== e.sym) begin
        errors++;
        $display("%0t: symbol mismatch, expected %0d, got %0d", $time, e.sym, s);
      end
      if (is_chk !== e.is_chk) begin
        errors++;
        $display("%0t: is_checksum mismatch, expected %0b, got %0b", $time, e.is_chk, is_chk);
      end
      if (fin !== e.fin) begin
        errors++;
        $display("%0t: last_symbol mismatch, expected %0b, got %0b", $time, e.fin, fin);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             in_cmd = 1'b0;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_is_last = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [SYM_W-1:0] out_symbol;
  logic             out_is_checksum;
  logic             out_last_symbol;

  symbol_scoreboard sb = new();

  // Idle modes; switched now and then so some stretches run back to back.
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  int unsigned requests_sent = 0;
  int unsigned requests_dropped = 0;
  int unsigned quiet_cycles = 0;

  always #4 clk = ~clk;

  polymod_checksum_payload_encoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_symbol      (out_symbol),
    .out_is_checksum (out_is_checksum),
    .out_last_symbol (out_last_symbol)
  );

  function automatic int unsigned draw_gap(bit idle_on);
    return idle_on ? $urandom_range(0, 8) : 0;
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  // Always entered right after a rising edge.
  task automatic send_request(bit cmd, logic [7:0] b, bit last);
    int unsigned gap;
    gap = draw_gap(send_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_data_byte <= b;
    in_is_last   <= last;
    do @(posedge clk); while (!in_ready);
    if (sb.note_request(cmd, b, last)) requests_dropped++;
    else requests_sent++;
  endtask

  // One address: prefix characters (with is_last noise, which prefixes
  // ignore), then payload bytes. Now and then a stray prefix lands inside
  // the payload; the encoder must drop it.
  task automatic send_address(int unsigned n_prefix, int unsigned n_bytes);
    for (int unsigned i = 0; i < n_prefix; i++)
      send_request(CMD_PREFIX, 8'($urandom), 1'($urandom));
    for (int unsigned i = 0; i < n_bytes; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0)
        send_request(CMD_PREFIX, 8'($urandom), 1'($urandom));
      send_request(CMD_PAYLOAD, 8'($urandom), i == n_bytes - 1);
    end
  endtask

  // Payload lengths: mostly short so every leftover count comes up often,
  // with a few address-sized runs.
  function automatic int unsigned draw_payload_len();
    case ($urandom_range(0, 9))
      7: return 21;
      8: return 33;
      9: return $urandom_range(9, 65);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Result checker: every accepted symbol goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_symbol, out_is_checksum, out_last_symbol);
  end

  // Watchdog: a long run with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random ready gaps per symbol. Twice it holds ready low for a
  // long stretch while the sender keeps going, so the work queue fills and
  // in_ready has to drop.
  initial begin
    int unsigned taken;
    int unsigned gap;
    taken = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (taken == 120 || taken == 500) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (taken % 25 == 0) recv_idle = $urandom_range(0, 3) != 0;
      gap = draw_gap(recv_idle);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Main sequence: reset, directed addresses, random addresses, drain.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty prefix, single all-ones byte: separator folded on the fly,
    // three leftover bits padded.
    send_request(CMD_PAYLOAD, 8'hFF, 1'b1);

    // Prefix extremes, is_last set on a prefix (ignored), then two bytes
    // leaving one bit to pad.
    send_request(CMD_PREFIX, 8'h00, 1'b0);
    send_request(CMD_PREFIX, 8'hFF, 1'b1);
    send_request(CMD_PREFIX, 8'h62, 1'b0);
    send_request(CMD_PAYLOAD, 8'h00, 1'b0);
    send_request(CMD_PAYLOAD, 8'hA5, 1'b1);

    // Five bytes = 40 bits, nothing to pad; a stray prefix mid-payload.
    send_request(CMD_PREFIX, 8'h1F, 1'b0);
    send_request(CMD_PAYLOAD, 8'h80, 1'b0);
    send_request(CMD_PAYLOAD, 8'h7F, 1'b0);
    send_request(CMD_PREFIX, 8'h41, 1'b1);
    send_request(CMD_PAYLOAD, 8'h01, 1'b0);
    send_request(CMD_PAYLOAD, 8'hFE, 1'b0);
    send_request(CMD_PAYLOAD, 8'h00, 1'b1);

    // Three bytes (four bits padded) and four bytes (two bits padded).
    send_request(CMD_PREFIX, 8'hE0, 1'b0);
    send_request(CMD_PAYLOAD, 8'hFF, 1'b0);
    send_request(CMD_PAYLOAD, 8'hFF, 1'b0);
    send_request(CMD_PAYLOAD, 8'hFF, 1'b1);
    send_request(CMD_PAYLOAD, 8'h55, 1'b0);
    send_request(CMD_PAYLOAD, 8'hAA, 1'b0);
    send_request(CMD_PAYLOAD, 8'h0F, 1'b0);
    send_request(CMD_PAYLOAD, 8'hF0, 1'b1);

    while (requests_sent < RANDOM_REQUESTS) begin
      send_idle = $urandom_range(0, 3) != 0;
      send_address($urandom_range(0, 6), draw_payload_len());
    end
    in_valid <= 1'b0;

    // Drain: the watchdog catches a block that never delivers.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d stray prefixes dropped), %0d addresses closed.",
             requests_sent, requests_dropped, sb.addresses_closed);
    $display("Checked %0d symbols, %0d mismatches.", sb.symbols_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
